// ----- rtl/cau_pkg.sv -----
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_SUB = 2'd1,
		FN_MUL = 2'd2,
		FN_DIV = 2'd3
	} func_t;

	// Per-beat control that travels with the data down the pipe.
	typedef struct packed {
		logic       valid;
		logic       use_q;    // result comes from the quotient
		logic       dz;       // divide by zero
		logic [1:0] neg;      // quotient sign, [0] real, [1] imag
		logic [1:0] pre_ovf;  // quotient magnitude known to exceed the word
	} ctrl_t;

endpackage

// ----- rtl/cau_front.sv -----
// Front stages: products, sums and divider setup.
module cau_front #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int NW = 2 * W + 1 + F
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  cau_pkg::func_t          func,
	input  logic signed [W-1:0]     a_real,
	input  logic signed [W-1:0]     a_imag,
	input  logic signed [W-1:0]     b_real,
	input  logic signed [W-1:0]     b_imag,
	output cau_pkg::ctrl_t          ctrl,
	output logic [1:0][NW-1:0]      num,
	output logic [1:0][2*W-1:0]     rem,
	output logic [2*W-1:0]          den
);

	// stage 1: products and plain sums
	logic                   valid_s1;
	cau_pkg::func_t         func_s1;
	logic signed [2*W-1:0]  ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [W:0]      sre_s1, sim_s1;

	// stage 2: full-precision values and squared magnitude
	logic                   valid_s2;
	logic                   div_s2;
	logic signed [2*W:0]    vre_s2, vim_s2;
	logic [2*W-1:0]         den_s2;

	logic signed [W:0]      sre_d, sim_d;
	logic signed [2*W:0]    vre_d, vim_d;
	logic signed [2*W:0]    ac_x, bd_x, ad_x, bc_x;

	always_comb begin
		if (func == cau_pkg::FN_SUB) begin
			sre_d = (W+1)'(a_real) - (W+1)'(b_real);
			sim_d = (W+1)'(a_imag) - (W+1)'(b_imag);
		end else begin
			sre_d = (W+1)'(a_real) + (W+1)'(b_real);
			sim_d = (W+1)'(a_imag) + (W+1)'(b_imag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			ac_s1   <= a_real * b_real;
			bd_s1   <= a_imag * b_imag;
			ad_s1   <= a_real * b_imag;
			bc_s1   <= a_imag * b_real;
			cc_s1   <= b_real * b_real;
			dd_s1   <= b_imag * b_imag;
			sre_s1  <= sre_d;
			sim_s1  <= sim_d;
		end
	end

	assign ac_x = (2*W+1)'(ac_s1);
	assign bd_x = (2*W+1)'(bd_s1);
	assign ad_x = (2*W+1)'(ad_s1);
	assign bc_x = (2*W+1)'(bc_s1);

	always_comb begin
		case (func_s1)
			cau_pkg::FN_MUL: begin
				vre_d = (ac_x - bd_x) >>> F;
				vim_d = (ad_x + bc_x) >>> F;
			end
			cau_pkg::FN_DIV: begin
				vre_d = ac_x + bd_x;
				vim_d = bc_x - ad_x;
			end
			default: begin
				vre_d = (2*W+1)'(sre_s1);
				vim_d = (2*W+1)'(sim_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= (func_s1 == cau_pkg::FN_DIV);
			vre_s2 <= vre_d;
			vim_s2 <= vim_d;
			den_s2 <= (2*W)'(cc_s1) + (2*W)'(dd_s1);
		end
	end

	// stage 3: magnitude, shift, range check and first partial remainder
	logic                   dz_d;
	logic                   useq_d;
	logic [1:0]             neg_d, povf_d;
	logic [1:0][NW-1:0]     num_d;
	logic [1:0][2*W-1:0]    rem_d;
	logic signed [2*W:0]    v [2];
	logic [2*W:0]           mag;
	logic [NW-1:0]          sh;

	assign v[0] = vre_s2;
	assign v[1] = vim_s2;

	always_comb begin
		dz_d   = div_s2 && (den_s2 == '0);
		useq_d = div_s2 && !dz_d;
		neg_d  = '0;
		povf_d = '0;
		num_d  = '0;
		rem_d  = '0;
		mag    = '0;
		sh     = '0;
		for (int l = 0; l < 2; l++) begin
			mag = v[l][2*W] ? (2*W+1)'(-v[l]) : (2*W+1)'(v[l]);
			sh  = NW'(mag) << F;
			if (useq_d) begin
				neg_d[l]  = v[l][2*W];
				povf_d[l] = NW'(sh >> W) >= NW'(den_s2);
				num_d[l]  = sh;
				rem_d[l]  = (2*W)'(sh >> W);
			end else if (!dz_d) begin
				num_d[l]  = NW'(v[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl <= '0;
		end else if (en) begin
			ctrl.valid   <= valid_s2;
			ctrl.use_q   <= useq_d;
			ctrl.dz      <= dz_d;
			ctrl.neg     <= neg_d;
			ctrl.pre_ovf <= povf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num <= num_d;
			rem <= rem_d;
			den <= den_s2;
		end
	end

endmodule

// ----- rtl/cau_div_step.sv -----
// One restoring division step for both result parts.
module cau_div_step #(
	parameter int W   = 32,
	parameter int NW  = 81,
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cau_pkg::ctrl_t      ctrl_in,
	input  logic [1:0][NW-1:0]  num_in,
	input  logic [1:0][2*W-1:0] rem_in,
	input  logic [1:0][W-1:0]   q_in,
	input  logic [2*W-1:0]      den_in,
	output cau_pkg::ctrl_t      ctrl_out,
	output logic [1:0][NW-1:0]  num_out,
	output logic [1:0][2*W-1:0] rem_out,
	output logic [1:0][W-1:0]   q_out,
	output logic [2*W-1:0]      den_out
);

	logic [1:0][2*W-1:0] rem_d;
	logic [1:0][W-1:0]   q_d;
	logic [2*W:0]        rsh, diff;
	logic                ge;

	always_comb begin
		rem_d = rem_in;
		q_d   = q_in;
		rsh   = '0;
		diff  = '0;
		ge    = 1'b0;
		for (int l = 0; l < 2; l++) begin
			rsh  = {rem_in[l], num_in[l][BIT]};
			diff = rsh - {1'b0, den_in};
			ge   = rsh >= {1'b0, den_in};
			rem_d[l]    = ge ? diff[2*W-1:0] : rsh[2*W-1:0];
			q_d[l][BIT] = ge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= num_in;
			rem_out <= rem_d;
			q_out   <= q_d;
			den_out <= den_in;
		end
	end

endmodule

// ----- rtl/cau_back.sv -----
// Result selection, saturation and output register.
module cau_back #(
	parameter int W  = 32,
	parameter int NW = 81,
	parameter int OW = 72
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  cau_pkg::ctrl_t      ctrl,
	input  logic [1:0][NW-1:0]  num,
	input  logic [1:0][W-1:0]   q,
	output logic                m_tvalid,
	output logic [OW-1:0]       m_tdata
);

	logic [1:0][W-1:0]   res;
	logic                ovf;
	logic signed [W:0]   qs;
	logic [2*W:0]        v;
	logic [W+1:0]        top;

	always_comb begin
		res = '0;
		ovf = 1'b0;
		qs  = '0;
		v   = '0;
		top = '0;
		for (int l = 0; l < 2; l++) begin
			qs  = ctrl.neg[l] ? -$signed({1'b0, q[l]}) : $signed({1'b0, q[l]});
			v   = ctrl.use_q ? (2*W+1)'(qs) : num[l][2*W:0];
			top = v[2*W:W-1];
			if (ctrl.use_q && ctrl.pre_ovf[l]) begin
				ovf    = 1'b1;
				res[l] = ctrl.neg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else if ((top == '0) || (top == '1)) begin
				res[l] = v[W-1:0];
			end else begin
				ovf    = 1'b1;
				res[l] = v[2*W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OW'({ctrl.dz, ovf, res[1], res[0]});
		end
	end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Throughput: one beat per cycle while the output is not stalled; every operation passes
// through three front stages, one stage per quotient bit of the restoring divider and one
// output register.
// The whole pipe holds while the output beat is not taken.
// Reset clears all valid bits; data registers are not reset.
module complex_arithmetic_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// func, a_real, a_imag, b_real, b_imag
	input  logic [((2+4*WORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// res_real, res_imag, overflow, div_by_zero
	output logic [((2*WORD_BITS+2+7)/8)*8-1:0] m_tdata
);

	localparam int W  = WORD_BITS;
	localparam int NW = 2 * W + 1 + FRAC_BITS;
	localparam int OW = ((2 * W + 2 + 7) / 8) * 8;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	cau_pkg::ctrl_t      ctrl_p [W+1];
	logic [1:0][NW-1:0]  num_p  [W+1];
	logic [1:0][2*W-1:0] rem_p  [W+1];
	logic [1:0][W-1:0]   q_p    [W+1];
	logic [2*W-1:0]      den_p  [W+1];

	assign q_p[0] = '0;

	cau_front #(.W(W), .F(FRAC_BITS), .NW(NW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.func     (cau_pkg::func_t'(s_tdata[1:0])),
		.a_real   (s_tdata[2+W-1:2]),
		.a_imag   (s_tdata[2+2*W-1:2+W]),
		.b_real   (s_tdata[2+3*W-1:2+2*W]),
		.b_imag   (s_tdata[2+4*W-1:2+3*W]),
		.ctrl     (ctrl_p[0]),
		.num      (num_p[0]),
		.rem      (rem_p[0]),
		.den      (den_p[0])
	);

	for (genvar k = 0; k < W; k++) begin : g_div
		cau_div_step #(.W(W), .NW(NW), .BIT(W-1-k)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_p[k]),
			.num_in   (num_p[k]),
			.rem_in   (rem_p[k]),
			.q_in     (q_p[k]),
			.den_in   (den_p[k]),
			.ctrl_out (ctrl_p[k+1]),
			.num_out  (num_p[k+1]),
			.rem_out  (rem_p[k+1]),
			.q_out    (q_p[k+1]),
			.den_out  (den_p[k+1])
		);
	end

	cau_back #(.W(W), .NW(NW), .OW(OW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl     (ctrl_p[W]),
		.num      (num_p[W]),
		.q        (q_p[W]),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- dv/complex_arithmetic_unit_test.sv -----
// Self-checking bench for the complex arithmetic unit: directed table, then random bursts.
module complex_arithmetic_unit_test;

	localparam int W = 32;
	localparam int F = 16;
	localparam int IN_W = ((2 + 4 * W + 7) / 8) * 8;
	localparam int OUT_W = ((2 * W + 2 + 7) / 8) * 8;
	localparam int N_RANDOM = 1500;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE = 1 <<< F;

	typedef struct packed {
		cau_pkg::func_t      fn;
		logic signed [W-1:0] ar, ai, br, bi;
	} operands_t;

	typedef struct packed {
		logic signed [W-1:0] re, im;
		logic              ovf, dz;
	} cplx_result_t;

	typedef struct {
		operands_t    op;
		logic         known;  // expected result typed into the row
		cplx_result_t res;
	} vector_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;

	complex_arithmetic_unit #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	cplx_result_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int received = 0;
	logic timed_out = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [W-1:0] clip(logic signed [255:0] v, inout logic ovf);
		if (v > 256'(signed'(WMAX))) begin
			ovf = 1;
			return WMAX;
		end
		if (v < 256'(signed'(WMIN))) begin
			ovf = 1;
			return WMIN;
		end
		return v[W-1:0];
	endfunction

	// Full-precision complex arithmetic at 256 bits, saturated at the end.
	function automatic cplx_result_t complex_op(operands_t o);
		logic signed [255:0] a, b, c, d, re, im, den, q;
		cplx_result_t r;
		a = o.ar;
		b = o.ai;
		c = o.br;
		d = o.bi;
		r = '0;
		case (o.fn)
			cau_pkg::FN_ADD: begin
				re = a + c;
				im = b + d;
			end
			cau_pkg::FN_SUB: begin
				re = a - c;
				im = b - d;
			end
			cau_pkg::FN_MUL: begin
				re = (a * c - b * d) >>> F;
				im = (a * d + b * c) >>> F;
			end
			default: begin
				if (c == 0 && d == 0) begin
					r.dz = 1;
					re = 0;
					im = 0;
				end else begin
					den = c * c + d * d;
					// signed / truncates toward zero
					re = ((a * c + b * d) <<< F) / den;
					im = ((b * c - a * d) <<< F) / den;
				end
			end
		endcase
		r.re = clip(re, r.ovf);
		r.im = clip(im, r.ovf);
		return r;
	endfunction

	function automatic logic signed [W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return WMAX;
			1: return WMIN;
			2: return W'(signed'($urandom_range(0, 8)) - 4);
			3: return W'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	task automatic send(operands_t o);
		s_tvalid <= 1;
		s_tdata <= IN_W'({o.bi, o.br, o.ai, o.ar, 2'(o.fn)});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_gap(int n);
		s_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Expectations are queued on acceptance so stalls never reorder them.
	always @(posedge clk) begin
		operands_t seen;
		cplx_result_t exp_r, got;
		if (arst_n && s_tvalid && s_tready) begin
			seen.fn = cau_pkg::func_t'(s_tdata[1:0]);
			seen.ar = s_tdata[2+W-1:2];
			seen.ai = s_tdata[2+2*W-1:2+W];
			seen.br = s_tdata[2+3*W-1:2+2*W];
			seen.bi = s_tdata[2+4*W-1:2+3*W];
			pending_results.push_back(complex_op(seen));
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[W-1:0], m_tdata[2*W-1:W], m_tdata[2*W], m_tdata[2*W+1]};
			received++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
							exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz,
							got.re, got.im, got.ovf, got.dz);
				end
			end
		end
	end

	// Receiver stalls: randomly chosen phases of free flow and random back-pressure.
	initial begin
		int phase;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			phase = $urandom_range(0, 2);
			repeat ($urandom_range(10, 80)) begin
				@(posedge clk);
				m_tready <= (phase == 0) ? 1'b1 : ($urandom_range(0, 3) >= phase);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out <= 1;
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		vector_t vectors[$];
		operands_t o;
		int burst;
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		vectors = '{
			'{'{cau_pkg::FN_ADD, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_ADD, WMAX, WMIN, ONE, -ONE}, 1, '{WMAX, WMIN, 1, 0}},
			'{'{cau_pkg::FN_ADD, WMIN, WMAX, WMIN, WMAX}, 1, '{WMIN, WMAX, 1, 0}},
			'{'{cau_pkg::FN_SUB, WMIN, WMAX, ONE, -ONE}, 1, '{WMIN, WMAX, 1, 0}},
			'{'{cau_pkg::FN_SUB, 5, -7, 5, -7}, 1, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_MUL, ONE, 0, ONE, 0}, 1, '{ONE, 0, 0, 0}},
			'{'{cau_pkg::FN_MUL, 0, ONE, 0, ONE}, 1, '{-ONE, 0, 0, 0}},
			'{'{cau_pkg::FN_MUL, WMAX, WMAX, WMAX, WMAX}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_MUL, WMIN, WMIN, WMIN, WMIN}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_MUL, -1, 0, 1, 0}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_DIV, ONE, ONE, 0, 0}, 1, '{0, 0, 0, 1}},
			'{'{cau_pkg::FN_DIV, WMAX, WMIN, 0, 0}, 1, '{0, 0, 0, 1}},
			'{'{cau_pkg::FN_DIV, ONE, 0, ONE, 0}, 1, '{ONE, 0, 0, 0}},
			'{'{cau_pkg::FN_DIV, WMAX, WMAX, 1, 0}, 1, '{WMAX, WMAX, 1, 0}},
			'{'{cau_pkg::FN_DIV, WMIN, WMIN, 1, 1}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_DIV, -1, 1, 3 * ONE, 0}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_DIV, WMIN, WMAX, WMIN, WMIN}, 0, '{0, 0, 0, 0}},
			'{'{cau_pkg::FN_DIV, 7, -3, WMAX, WMIN}, 0, '{0, 0, 0, 0}}
		};
		foreach (vectors[i]) begin
			if (vectors[i].known && complex_op(vectors[i].op) !== vectors[i].res) begin
				mismatches++;
				if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
			end
			send(vectors[i].op);
		end
		s_tvalid <= 0;

		// hold off until the pipe has fully drained
		wait (pending_results.size() == 0);
		@(posedge clk);

		for (int n = 0; n < N_RANDOM; ) begin
			burst = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 20);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				o.fn = cau_pkg::func_t'($urandom_range(0, 3));
				o.ar = rand_word();
				o.ai = rand_word();
				o.br = rand_word();
				o.bi = rand_word();
				if (o.fn == cau_pkg::FN_DIV && $urandom_range(0, 9) == 0) begin
					o.br = 0;
					o.bi = 0;
				end
				send(o);
			end
			if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 12));
		end
		s_tvalid <= 0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
